// ===== hdl/ajs_pkg.sv =====
// Shared types and constants for the aging priority job scheduler.
// No dependencies. Used by the cell row, the top level and the checker.
package ajs_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SLOT_W    = 4;
	localparam int TIME_W    = 16;
	localparam int PRIO_W    = 32;

	typedef enum logic {
		OP_ADMIT = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef struct packed {
		op_t               operation;
		logic [SLOT_W-1:0] job_slot;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
	} in_t;

	typedef struct packed {
		logic [SLOT_W-1:0]        job_slot_out;
		logic [TIME_W-1:0]        ready_time;
		logic [TIME_W-1:0]        dispatch_time;
		logic [TIME_W-1:0]        leave_time;
		logic [TIME_W-1:0]        run_length;
		logic [TIME_W-1:0]        wait_ticks;
		logic signed [PRIO_W-1:0] dispatch_priority;
	} out_t;

	// candidate handed along the cell row during the minimum scan
	typedef struct packed {
		logic                     valid;
		logic [SLOT_W-1:0]        slot;
		logic [TIME_W-1:0]        start_time;
		logic [TIME_W-1:0]        end_time;
		logic [TIME_W-1:0]        wait_count;
		logic signed [PRIO_W-1:0] prio;
	} cand_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic              load;
		logic [SLOT_W-1:0] load_slot;
		logic [TIME_W-1:0] load_start;
		logic [TIME_W-1:0] load_end;
		logic              act;
		logic [TIME_W-1:0] cur_time;
		logic              age;
		logic              disp;
		logic [SLOT_W-1:0] disp_slot;
	} ctl_t;

endpackage

// ===== hdl/ajs_cell.sv =====
// One job slot of the scheduler row: slot state, activation, aging and one
// stage of the minimum scan. Depends on ajs_pkg.
module ajs_cell #(
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ajs_pkg::ctl_t  ctl,
	input  ajs_pkg::cand_t cand_in,
	output ajs_pkg::cand_t cand_out
);
	import ajs_pkg::*;

	logic                     pending_q;
	logic                     waiting_q;
	logic [TIME_W-1:0]        start_q;
	logic [TIME_W-1:0]        end_q;
	logic [TIME_W-1:0]        wcnt_q;
	logic signed [PRIO_W-1:0] prio_q;
	cand_t                    cand_q;

	logic                     load_hit;
	logic                     act_hit;
	logic                     disp_hit;
	logic                     take_own;
	logic [TIME_W-1:0]        wcnt_inc;
	logic signed [PRIO_W:0]   diff;
	logic signed [PRIO_W-1:0] prio_aged;
	cand_t                    own;

	assign load_hit = ctl.load && (INDEX == int'(ctl.load_slot));
	assign act_hit  = ctl.act && pending_q && (start_q == ctl.cur_time);
	assign disp_hit = ctl.disp && (INDEX == int'(ctl.disp_slot));

	assign wcnt_inc = (wcnt_q == {TIME_W{1'b1}}) ? wcnt_q : wcnt_q + TIME_W'(1);
	assign diff     = {prio_q[PRIO_W-1], prio_q} - $signed({1'b0, {(PRIO_W-TIME_W){1'b0}}, wcnt_inc});
	// only ever decreases, so a sign mismatch means it ran below the minimum
	assign prio_aged = (diff[PRIO_W] != diff[PRIO_W-1]) ?
		{1'b1, {(PRIO_W-1){1'b0}}} : diff[PRIO_W-1:0];

	assign own.valid      = waiting_q;
	assign own.slot       = SLOT_W'(INDEX);
	assign own.start_time = start_q;
	assign own.end_time   = end_q;
	assign own.wait_count = wcnt_q;
	assign own.prio       = prio_q;

	// strict less: ties stay with the lower slot coming down the row
	assign take_own = waiting_q && (!cand_in.valid || (prio_q < cand_in.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			waiting_q <= 1'b0;
			cand_q    <= '0;
		end else begin
			cand_q <= take_own ? own : cand_in;
			priority if (load_hit) begin
				pending_q <= 1'b1;
				waiting_q <= 1'b0;
			end else if (act_hit) begin
				pending_q <= 1'b0;
				waiting_q <= 1'b1;
			end else if (ctl.age && waiting_q && disp_hit) begin
				waiting_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (load_hit) begin
			start_q <= ctl.load_start;
			end_q   <= ctl.load_end;
			wcnt_q  <= '0;
			prio_q  <= '0;
		end else if (act_hit) begin
			prio_q <= $signed({{(PRIO_W-TIME_W){1'b0}}, end_q});
			wcnt_q <= '0;
		end else if (ctl.age && waiting_q && !disp_hit) begin
			wcnt_q <= wcnt_inc;
			prio_q <= prio_aged;
		end
	end

	assign cand_out = cand_q;

endmodule

// ===== hdl/aging_priority_job_scheduler.sv =====
// Top level of the aging priority job scheduler: sequencer, time keeping,
// busy period and result register around a row of ajs_cell. Depends on ajs_pkg.
//
//   channel   handshake              payload          transfer
//   input     start / busy           item   (in_t)    start && !busy
//   result    result_strobe          result (out_t)   one cycle, no back-pressure
//
// An admit loads its slot and busy stays low. A tick advances the time, then
// activates due jobs, lets the candidate wave travel the cell row, and then
// dispatches and ages. A result appears in the cycle after the tick's last busy
// cycle. Reset clears all slot flags, the time and the busy period; the
// receiver cannot stall the result.
module aging_priority_job_scheduler #(
	parameter int SLOTS = ajs_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ajs_pkg::in_t  item,
	output logic          result_strobe,
	output ajs_pkg::out_t result
);
	import ajs_pkg::*;

	localparam int CNT_W = $clog2(SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACT,
		ST_SCAN,
		ST_DISP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] time_q;
	logic              busy_flag_q;
	logic [TIME_W-1:0] busy_until_q;
	out_t              result_q;
	logic              result_strobe_q;

	cand_t             cand_w [SLOTS+1];
	cand_t             best;
	ctl_t              ctl;
	logic              accept;
	logic              dispatch;
	logic [TIME_W-1:0] next_time;
	logic [TIME_W-1:0] run;
	logic [TIME_W-1:0] leave;

	assign accept    = start && !busy;
	assign next_time = time_q + TIME_W'(1);
	assign best      = cand_w[SLOTS];
	assign dispatch  = (state_q == ST_DISP) && best.valid && !busy_flag_q;
	assign run       = best.end_time - best.start_time;
	assign leave     = time_q + run;

	assign ctl.load       = accept && (item.operation == OP_ADMIT) &&
		(item.end_time > item.start_time);
	assign ctl.load_slot  = item.job_slot;
	assign ctl.load_start = item.start_time;
	assign ctl.load_end   = item.end_time;
	assign ctl.act        = (state_q == ST_ACT);
	assign ctl.cur_time   = time_q;
	assign ctl.age        = (state_q == ST_DISP);
	assign ctl.disp       = dispatch;
	assign ctl.disp_slot  = best.slot;

	assign cand_w[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ajs_cell #(
			.INDEX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.cand_in (cand_w[i]),
			.cand_out(cand_w[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			time_q          <= '0;
			busy_flag_q     <= 1'b0;
			busy_until_q    <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.operation == OP_TICK) begin
						time_q <= next_time;
						if (busy_flag_q && next_time == busy_until_q)
							busy_flag_q <= 1'b0;
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SLOTS - 1))
						state_q <= ST_DISP;
				end
				ST_DISP: begin
					if (dispatch) begin
						busy_flag_q     <= 1'b1;
						busy_until_q    <= leave;
						result_strobe_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dispatch) begin
			result_q.job_slot_out      <= best.slot;
			result_q.ready_time        <= best.start_time;
			result_q.dispatch_time     <= time_q;
			result_q.leave_time        <= leave;
			result_q.run_length        <= run;
			result_q.wait_ticks        <= best.wait_count;
			result_q.dispatch_priority <= best.prio;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = result_strobe_q;
	assign result        = result_q;

endmodule

// ===== hdl/ajs_checker.sv =====
// Port-level checks for the aging priority job scheduler, bound to the top
// level. Depends on ajs_pkg.
module ajs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ajs_pkg::in_t  item,
	input logic          result_strobe,
	input ajs_pkg::out_t result
);
	import ajs_pkg::*;

	// a result only follows a finished tick, with the block idle again
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !busy)
		else $error("result strobe while busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("result strobe on consecutive cycles");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_TICK) |=> busy)
		else $error("tick transfer did not make the block busy");

	a_admit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_ADMIT) |=> (!busy && !result_strobe))
		else $error("admit transfer caused busy or a result");

	a_leave_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.run_length != '0 &&
			result.leave_time == TIME_W'(result.dispatch_time + result.run_length)))
		else $error("inconsistent leave time or zero run length");

endmodule

bind aging_priority_job_scheduler ajs_checker u_ajs_checker (.*);

// ===== tb/tb_aging_priority_job_scheduler.sv =====
// Self-checking testbench for aging_priority_job_scheduler: directed and random
// admit/tick items against an in-bench scheduling predictor.
// Depends on ajs_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_aging_priority_job_scheduler;
	import ajs_pkg::*;

	localparam int     SLOTS       = SLOTS_DEF;
	localparam int     QUIET_LIMIT = 4000;
	localparam longint PRIO_FLOOR  = -64'sd2147483648;

	typedef struct {
		in_t item;
		int  idle_pct;
	} job_plan_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	in_t  item   = '0;
	logic busy;
	logic result_strobe;
	out_t result;

	job_plan_t pending_items[$];
	out_t      expected_dispatches[$];
	int        mismatches      = 0;
	int        quiet_cycles    = 0;
	int        sender_idle_pct = 0;
	bit [15:0] plan_time       = '0;

	// predicted scheduler state
	bit          job_pending [SLOTS];
	bit          job_waiting [SLOTS];
	bit [15:0]   job_start   [SLOTS];
	bit [15:0]   job_end     [SLOTS];
	bit [15:0]   job_wait    [SLOTS];
	longint      job_prio    [SLOTS];
	bit [15:0]   sched_now   = '0;
	bit [15:0]   busy_till   = '0;
	bit          busy_mark   = 1'b0;

	aging_priority_job_scheduler #(.SLOTS(SLOTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one accepted item to the predicted state; returns 1 when a job is dispatched.
	function automatic bit schedule_step(input in_t it, output out_t disp);
		int        s;
		int        pick;
		bit [15:0] run;
		longint    aged;
		disp = '0;
		if (it.operation == OP_ADMIT) begin
			if (int'(it.job_slot) < SLOTS && it.end_time > it.start_time) begin
				job_start[it.job_slot]   = it.start_time;
				job_end[it.job_slot]     = it.end_time;
				job_wait[it.job_slot]    = '0;
				job_prio[it.job_slot]    = 0;
				job_pending[it.job_slot] = 1'b1;
				job_waiting[it.job_slot] = 1'b0;
			end
			return 1'b0;
		end
		sched_now = sched_now + 16'd1;
		if (busy_mark && sched_now == busy_till)
			busy_mark = 1'b0;
		for (s = 0; s < SLOTS; s++) begin
			if (job_pending[s] && job_start[s] == sched_now) begin
				job_pending[s] = 1'b0;
				job_waiting[s] = 1'b1;
				job_prio[s]    = longint'(job_end[s]);
				job_wait[s]    = '0;
			end
		end
		pick = -1;
		if (!busy_mark) begin
			for (s = 0; s < SLOTS; s++) begin
				if (job_waiting[s] && (pick < 0 || job_prio[s] < job_prio[pick]))
					pick = s;
			end
		end
		if (pick >= 0) begin
			run                    = job_end[pick] - job_start[pick];
			disp.job_slot_out      = SLOT_W'(pick);
			disp.ready_time        = job_start[pick];
			disp.dispatch_time     = sched_now;
			disp.leave_time        = sched_now + run;
			disp.run_length        = run;
			disp.wait_ticks        = job_wait[pick];
			disp.dispatch_priority = job_prio[pick][31:0];
			job_waiting[pick]      = 1'b0;
			busy_mark              = 1'b1;
			busy_till              = sched_now + run;
		end
		// aging of everything still waiting, after the dispatch decision
		for (s = 0; s < SLOTS; s++) begin
			if (job_waiting[s]) begin
				if (job_wait[s] != 16'hFFFF)
					job_wait[s] = job_wait[s] + 16'd1;
				aged = job_prio[s] - longint'(job_wait[s]);
				if (aged < PRIO_FLOOR)
					aged = PRIO_FLOOR;
				job_prio[s] = aged;
			end
		end
		return pick >= 0;
	endfunction

	task automatic plan_admit(input logic [3:0] slot, input logic [15:0] st, input logic [15:0] en);
		job_plan_t p;
		p.item.operation  = OP_ADMIT;
		p.item.job_slot   = slot;
		p.item.start_time = st;
		p.item.end_time   = en;
		p.idle_pct        = sender_idle_pct;
		pending_items.push_back(p);
	endtask

	task automatic plan_ticks(input int n);
		job_plan_t p;
		p.item.operation  = OP_TICK;
		p.idle_pct        = sender_idle_pct;
		repeat (n) begin
			p.item.job_slot   = 4'($urandom);
			p.item.start_time = 16'($urandom);
			p.item.end_time   = 16'($urandom);
			pending_items.push_back(p);
			plan_time = plan_time + 16'd1;
		end
	endtask

	task automatic check_field(input string what, input logic signed [32:0] want,
			input logic signed [32:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// driver: present the next planned item whenever the previous one has transferred
	always @(posedge clk or negedge arst_n) begin
		job_plan_t nxt;
		out_t      disp;
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			if (start && !busy) begin
				if (schedule_step(item, disp))
					expected_dispatches.push_back(disp);
			end
			if (!start || !busy) begin
				if (pending_items.size() != 0 &&
						$urandom_range(0, 99) >= pending_items[0].idle_pct) begin
					nxt = pending_items.pop_front();
					start <= 1'b1;
					item  <= nxt.item;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_strobe) begin
			if (expected_dispatches.size() == 0) begin
				$display("%0t: dispatch of slot %0d with none expected", $time,
					result.job_slot_out);
				mismatches++;
			end else begin
				want = expected_dispatches.pop_front();
				check_field("job_slot_out", want.job_slot_out, result.job_slot_out);
				check_field("ready_time", want.ready_time, result.ready_time);
				check_field("dispatch_time", want.dispatch_time, result.dispatch_time);
				check_field("leave_time", want.leave_time, result.leave_time);
				check_field("run_length", want.run_length, result.run_length);
				check_field("wait_ticks", want.wait_ticks, result.wait_ticks);
				check_field("dispatch_priority", want.dispatch_priority,
					result.dispatch_priority);
			end
		end
	end

	// watchdog on cycles with no transfer in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int        phase;
		int        queued;
		int        dice;
		int        n;
		bit [15:0] st;
		bit [15:0] en;

		sender_idle_pct = 6;
		// long job from the first tick keeps the block busy, so the jobs behind it age
		plan_admit(4'd0, 16'd1, 16'd60);
		plan_admit(4'd1, 16'd2, 16'd12);
		plan_admit(4'd2, 16'd2, 16'd40);
		plan_admit(4'd3, 16'd3, 16'd3);         // end equal to start: ignored
		plan_admit(4'd4, 16'd65535, 16'd1);     // end before start: ignored
		plan_admit(4'd5, 16'd1, 16'd100);
		plan_admit(4'd5, 16'd30000, 16'd30005); // replaces a pending job
		plan_admit(4'd6, 16'd2, 16'd50);
		plan_ticks(10);
		plan_admit(4'd6, 16'd15, 16'd70);       // replaces a waiting job
		plan_admit(4'd7, 16'd5, 16'd20);        // start already passed: stays pending
		plan_admit(4'd8, 16'd65534, 16'd65535);
		plan_ticks(120);
		// equal priority joining on the same tick: lower slot first
		plan_admit(4'd15, plan_time + 16'd2, plan_time + 16'd10);
		plan_admit(4'd9, plan_time + 16'd2, plan_time + 16'd10);
		plan_ticks(12);

		for (phase = 0; phase < 3; phase++) begin
			sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 58 : 0;
			queued = 0;
			while (queued < 360) begin
				dice = $urandom_range(0, 99);
				if (dice < 50) begin
					st = plan_time + 16'($urandom_range(1, 12));
					en = st + 16'($urandom_range(1, 20));
					plan_admit(4'($urandom), st, en);
					queued++;
				end else if (dice < 85) begin
					n = $urandom_range(1, 4);
					plan_ticks(n);
					queued += n;
				end else if (dice < 93) begin
					// far-future start so a stray long job cannot stall the run
					plan_admit(4'($urandom), 16'($urandom) | 16'h4000, 16'($urandom));
					queued++;
				end else begin
					st = plan_time + 16'($urandom_range(1, 12));
					en = st - 16'($urandom_range(0, 3));
					plan_admit(4'($urandom), st, en);
					queued++;
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start || busy || expected_dispatches.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ajs_pkg.sv
hdl/ajs_cell.sv
hdl/aging_priority_job_scheduler.sv
hdl/ajs_checker.sv
tb/tb_aging_priority_job_scheduler.sv
